// ===== rtl/mots_pkg.sv =====
// Package for the smallest-first topological sort block.
// Holds sizes, status codes, shared types and the ready-vertex search.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mots_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int VidW        = 7;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int EIdxW       = $clog2(MaxEdges);
  localparam int LinkW       = $clog2(MaxEdges + 1);
  localparam int DegW        = 9;
  localparam int StatW       = 2;

  localparam logic [StatW-1:0] StatusOk       = 2'd0;
  localparam logic [StatW-1:0] StatusCycle    = 2'd1;
  localparam logic [StatW-1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic             en;
    logic [VIdxW-1:0] addr;
    logic [DegW-1:0]  data;
  } vmem_wr_t;

  typedef struct packed {
    logic [VIdxW-1:0] target;
    logic [LinkW-1:0] next;
  } edge_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_INIT,
    S_PICK,
    S_HEAD,
    S_EDGE,
    S_ECHK,
    S_DEC,
    S_ORD_RD,
    S_ORD_LD,
    S_OUT
  } state_e;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [VIdxW-1:0] first_set(input logic [MaxVertices-1:0] m);
    logic [VIdxW-1:0] r;
    r = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (m[i]) r = VIdxW'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mots_ram.sv =====
// Generic synchronous RAM, one write port and one registered read port.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module mots_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mots_vmem.sv =====
// Per-vertex memory whose entries read as zero until written since the last clear.
// Depends on mots_pkg for sizes and the write request type.
`timescale 1ns / 1ps
`default_nettype none

module mots_vmem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clr_i,
  input  wire mots_pkg::vmem_wr_t            wr_i,
  input  wire logic [mots_pkg::VIdxW-1:0]    raddr_i,
  output logic      [mots_pkg::DegW-1:0]     rdata_o
);

  logic [mots_pkg::DegW-1:0]        mem [mots_pkg::MaxVertices];
  logic [mots_pkg::MaxVertices-1:0] vld_q;
  logic [mots_pkg::DegW-1:0]        rd_q;
  logic                             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/min_order_topological_sort.sv =====
// Top level of the smallest-first topological sort (Kahn's algorithm).
// Depends on mots_pkg, mots_vmem and mots_ram.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------------
//   in       | input     | in_valid_i / in_stall_o | edge_valid, edge_from, edge_to, last_edge
//   out      | output    | out_valid_o / out_stall_i | vertex_id, status, last_result
//   cfg      | input     | cfg_we_i                | cfg_wdata_i = vertex_count
//
// An edge transaction reads the list head and in-degree memories, then writes them
// back. After the last transaction the sort sweeps the in-degrees, then, for each
// ordered vertex, reads its list head and walks its edges, reading and decrementing
// the in-degree of each target. Each result is read from the order memory, then
// held until taken. Reset needs no clearing pass: the in-degree and list-head
// memories carry a valid bit per entry, dropped at reset and at the end of each run.
// The input is stalled while each stored edge is written back, and from the last
// transaction of a graph until its last result is taken.
`timescale 1ns / 1ps
`default_nettype none

module min_order_topological_sort (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mots_pkg::VidW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        edge_valid_i,
  input  wire logic [mots_pkg::VidW-1:0]   edge_from_i,
  input  wire logic [mots_pkg::VidW-1:0]   edge_to_i,
  input  wire logic                        last_edge_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [mots_pkg::VidW-1:0]   vertex_id_o,
  output logic      [mots_pkg::StatW-1:0]  status_o,
  output logic                             last_result_o
);

  localparam int VW = mots_pkg::VidW;
  localparam int IW = mots_pkg::VIdxW;
  localparam int LW = mots_pkg::LinkW;
  localparam int NV = mots_pkg::MaxVertices;

  mots_pkg::state_e state_q, state_d;

  // The vertex count register and its clamped value used everywhere else.
  logic [VW-1:0] vcount_q;
  logic [VW-1:0] vc;

  always_comb begin
    if (vcount_q == '0) begin
      vc = VW'(1);
    end else if (vcount_q > VW'(NV)) begin
      vc = VW'(NV);
    end else begin
      vc = vcount_q;
    end
  end

  logic [LW-1:0]   edge_count_q, edge_count_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [IW-1:0]   from_q, from_d, to_q, to_d;
  logic [NV-1:0]   ready_q, ready_d, visited_q, visited_d;
  logic [VW-1:0]   cnt_q, cnt_d, ordered_q, ordered_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   pidx_q, pidx_d, tgt_q, tgt_d, k_q, k_d;
  logic [LW-1:0]   link_q, link_d;
  logic            out_valid_q, out_valid_d;
  logic [VW-1:0]   out_vid_q, out_vid_d;
  logic [mots_pkg::StatW-1:0] out_stat_q, out_stat_d;
  logic            out_last_q, out_last_d;

  // Memory ports.
  logic                       clr;
  mots_pkg::vmem_wr_t         head_wr, deg_wr;
  logic [IW-1:0]              head_raddr, deg_raddr;
  logic [mots_pkg::DegW-1:0]  head_rdata, deg_rdata;
  logic                       edge_we;
  logic [mots_pkg::EIdxW-1:0] edge_waddr, edge_raddr;
  mots_pkg::edge_ent_t        edge_wdata, edge_rdata;
  logic                       ord_we;
  logic [IW-1:0]              ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  mots_vmem u_head (
    .clk_i, .rst_ni, .clr_i(clr), .wr_i(head_wr), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  mots_vmem u_deg (
    .clk_i, .rst_ni, .clr_i(clr), .wr_i(deg_wr), .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  mots_ram #(
    .Width($bits(mots_pkg::edge_ent_t)), .Depth(mots_pkg::MaxEdges)
  ) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  mots_ram #(
    .Width(IW), .Depth(NV)
  ) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  logic in_acc, out_acc, good;
  logic [IW-1:0] from_idx, to_idx, now_idx;
  logic [VW-1:0] tgt_vid;

  assign in_acc   = in_valid_i && (state_q == mots_pkg::S_IDLE);
  assign out_acc  = out_valid_q && !out_stall_i;
  assign from_idx = IW'(edge_from_i - VW'(1));
  assign to_idx   = IW'(edge_to_i - VW'(1));
  assign now_idx  = mots_pkg::first_set(ready_q);
  assign tgt_vid  = {1'b0, edge_rdata.target} + VW'(1);
  assign good     = (edge_from_i != '0) && (edge_from_i <= vc) &&
                    (edge_to_i != '0) && (edge_to_i <= vc) &&
                    (edge_count_q < LW'(mots_pkg::MaxEdges));

  always_comb begin
    state_d      = state_q;
    edge_count_d = edge_count_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    from_d       = from_q;
    to_d         = to_q;
    ready_d      = ready_q;
    visited_d    = visited_q;
    cnt_d        = cnt_q;
    ordered_d    = ordered_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    tgt_d        = tgt_q;
    k_d          = k_q;
    link_d       = link_q;
    out_valid_d  = out_valid_q;
    out_vid_d    = out_vid_q;
    out_stat_d   = out_stat_q;
    out_last_d   = out_last_q;
    clr          = 1'b0;
    head_wr      = '0;
    deg_wr       = '0;
    head_raddr   = from_idx;
    deg_raddr    = to_idx;
    edge_we      = 1'b0;
    edge_waddr   = edge_count_q[mots_pkg::EIdxW-1:0];
    edge_wdata   = '0;
    edge_raddr   = '0;
    ord_we       = 1'b0;
    ord_waddr    = ordered_q[IW-1:0];
    ord_wdata    = now_idx;
    ord_raddr    = k_q;

    unique case (state_q)
      mots_pkg::S_IDLE: begin
        if (in_acc) begin
          if (edge_valid_i && good) begin
            // Read list head and in-degree now, write them back next cycle.
            from_d  = from_idx;
            to_d    = to_idx;
            last_d  = last_edge_i;
            state_d = mots_pkg::S_LOAD;
          end else begin
            ovf_d = ovf_q || edge_valid_i;
            if (last_edge_i) begin
              if (ovf_d) begin
                out_valid_d = 1'b1;
                out_vid_d   = '0;
                out_stat_d  = mots_pkg::StatusOverflow;
                out_last_d  = 1'b1;
                state_d     = mots_pkg::S_OUT;
              end else begin
                cnt_d   = '0;
                state_d = mots_pkg::S_INIT;
              end
            end
          end
        end
      end

      mots_pkg::S_LOAD: begin
        edge_we           = 1'b1;
        edge_wdata.target = to_q;
        edge_wdata.next   = head_rdata;
        head_wr.en        = 1'b1;
        head_wr.addr      = from_q;
        head_wr.data      = edge_count_q + LW'(1);
        deg_wr.en         = 1'b1;
        deg_wr.addr       = to_q;
        deg_wr.data       = deg_rdata + mots_pkg::DegW'(1);
        edge_count_d      = edge_count_q + LW'(1);
        if (!last_q) begin
          state_d = mots_pkg::S_IDLE;
        end else if (ovf_q) begin
          out_valid_d = 1'b1;
          out_vid_d   = '0;
          out_stat_d  = mots_pkg::StatusOverflow;
          out_last_d  = 1'b1;
          state_d     = mots_pkg::S_OUT;
        end else begin
          cnt_d   = '0;
          state_d = mots_pkg::S_INIT;
        end
      end

      // Sweep the in-degrees; a read issued in a cycle is checked in the next.
      mots_pkg::S_INIT: begin
        deg_raddr = cnt_q[IW-1:0];
        if (pend_q && (deg_rdata == '0)) ready_d[pidx_q] = 1'b1;
        if (cnt_q < vc) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + VW'(1);
        end else if (!pend_q) begin
          state_d = mots_pkg::S_PICK;
        end
      end

      mots_pkg::S_PICK: begin
        head_raddr = now_idx;
        if (ready_q == '0) begin
          out_valid_d = 1'b0;
          if (ordered_q == vc) begin
            k_d     = '0;
            state_d = mots_pkg::S_ORD_RD;
          end else begin
            out_valid_d = 1'b1;
            out_vid_d   = '0;
            out_stat_d  = mots_pkg::StatusCycle;
            out_last_d  = 1'b1;
            state_d     = mots_pkg::S_OUT;
          end
        end else begin
          ready_d[now_idx]   = 1'b0;
          visited_d[now_idx] = 1'b1;
          ord_we             = 1'b1;
          ordered_d          = ordered_q + VW'(1);
          state_d            = mots_pkg::S_HEAD;
        end
      end

      mots_pkg::S_HEAD: begin
        link_d  = head_rdata;
        state_d = mots_pkg::S_EDGE;
      end

      mots_pkg::S_EDGE: begin
        edge_raddr = mots_pkg::EIdxW'(link_q - LW'(1));
        if (link_q == '0) begin
          state_d = mots_pkg::S_PICK;
        end else begin
          state_d = mots_pkg::S_ECHK;
        end
      end

      mots_pkg::S_ECHK: begin
        deg_raddr = edge_rdata.target;
        link_d    = edge_rdata.next;
        tgt_d     = edge_rdata.target;
        if (tgt_vid > vc) begin
          state_d = mots_pkg::S_EDGE;
        end else if (visited_q[edge_rdata.target]) begin
          out_valid_d = 1'b1;
          out_vid_d   = '0;
          out_stat_d  = mots_pkg::StatusCycle;
          out_last_d  = 1'b1;
          state_d     = mots_pkg::S_OUT;
        end else begin
          state_d = mots_pkg::S_DEC;
        end
      end

      mots_pkg::S_DEC: begin
        if (deg_rdata != '0) begin
          deg_wr.en   = 1'b1;
          deg_wr.addr = tgt_q;
          deg_wr.data = deg_rdata - mots_pkg::DegW'(1);
          if (deg_rdata == mots_pkg::DegW'(1)) ready_d[tgt_q] = 1'b1;
        end
        state_d = mots_pkg::S_EDGE;
      end

      mots_pkg::S_ORD_RD: begin
        state_d = mots_pkg::S_ORD_LD;
      end

      mots_pkg::S_ORD_LD: begin
        out_valid_d = 1'b1;
        out_vid_d   = {1'b0, ord_rdata} + VW'(1);
        out_stat_d  = mots_pkg::StatusOk;
        out_last_d  = ({1'b0, k_q} + VW'(1)) == ordered_q;
        state_d     = mots_pkg::S_OUT;
      end

      mots_pkg::S_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            // End of run: drop the whole graph.
            clr          = 1'b1;
            edge_count_d = '0;
            ovf_d        = 1'b0;
            ready_d      = '0;
            visited_d    = '0;
            ordered_d    = '0;
            state_d      = mots_pkg::S_IDLE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = mots_pkg::S_ORD_RD;
          end
        end
      end

      default: state_d = mots_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mots_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q     <= VW'(1);
      edge_count_q <= '0;
      ovf_q        <= 1'b0;
      ready_q      <= '0;
      visited_q    <= '0;
      ordered_q    <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      edge_count_q <= edge_count_d;
      ovf_q        <= ovf_d;
      ready_q      <= ready_d;
      visited_q    <= visited_d;
      ordered_q    <= ordered_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    from_q     <= from_d;
    to_q       <= to_d;
    cnt_q      <= cnt_d;
    pidx_q     <= pidx_d;
    tgt_q      <= tgt_d;
    k_q        <= k_d;
    link_q     <= link_d;
    out_vid_q  <= out_vid_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != mots_pkg::S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign vertex_id_o   = out_vid_q;
  assign status_o      = out_stat_q;
  assign last_result_o = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/mots_checker.sv =====
// Port-level checks for the topological sort block, bound to its top level.
// Depends on mots_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module mots_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [mots_pkg::VidW-1:0]   vertex_id_o,
  input wire logic [mots_pkg::StatW-1:0]  status_o,
  input wire logic                        last_result_o
);

  // A failure result is the only one of its run and carries no vertex.
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != mots_pkg::StatusOk) |-> last_result_o && (vertex_id_o == '0))
    else $error("failure result not marked last or carries a vertex");

  a_ok_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mots_pkg::StatusOk) |-> (vertex_id_o != '0))
    else $error("ordered result carries vertex zero");

  // No new edge transaction is taken while results of a run are pending.
  a_no_load_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_id_o))
    else $error("stalled result changed");

endmodule

bind min_order_topological_sort mots_checker u_mots_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .vertex_id_o, .status_o, .last_result_o
);

`default_nettype wire
